// ===== rtl/core/triangle_midpoint_texel_sampler_top_defines.svh =====
// Assertion macros used by the back end of the triangle midpoint texel sampler.
`ifndef TRIANGLE_MIDPOINT_TEXEL_SAMPLER_TOP_DEFINES_SVH
`define TRIANGLE_MIDPOINT_TEXEL_SAMPLER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TMTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TMTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tmts_pkg.sv =====
// Types, constants and arithmetic helpers of the triangle midpoint texel sampler.
package tmts_pkg;

   localparam int POS_W           = 32;
   localparam int COORD_W         = 20;
   localparam int COORD_FRAC_BITS = 16;
   localparam int SUM_W           = COORD_W + 1;
   localparam int FRAC_SUM_W      = COORD_FRAC_BITS + 1;
   localparam int DIM_W           = 9;
   localparam int COORD_IDX_W     = 8;
   localparam int RGB_W           = 24;
   localparam int CHAN_W          = 8;
   localparam int TEXEL_ADDR_W    = 16;
   localparam int TEXEL_DEPTH     = 1 << TEXEL_ADDR_W;
   localparam int CSR_IDX_W       = 2;

   localparam int JOB_DEPTH       = 4;
   localparam int JOB_PTR_W       = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W       = JOB_PTR_W + 1;
   localparam int OUT_DEPTH       = 8;
   localparam int OUT_PTR_W       = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W       = OUT_PTR_W + 1;

   localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(1);
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(256);

   localparam logic CMD_TEXEL_WRITE = 1'b0;
   localparam logic CMD_VERTEX      = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_PRESENT = CSR_IDX_W'(2);

   localparam logic [1:0] LAST_CORNER = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      pos_type            pos;
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
   } corner_type;

   typedef struct packed {
      logic                    is_write;
      pos_type                 pos;
      logic [SUM_W-1:0]        du;
      logic [SUM_W-1:0]        dv;
      logic                    final_point;
      logic [TEXEL_ADDR_W-1:0] texel_index;
      logic [RGB_W-1:0]        rgb;
   } job_type;

   typedef struct packed {
      pos_type          pos;
      logic [RGB_W-1:0] rgb;
      logic             final_point;
   } point_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             present;
   } cfg_type;

   // floor((a + b) / 2) on the full 33-bit sum
   function automatic logic signed [POS_W-1:0] mid_pos(input logic signed [POS_W-1:0] a,
                                                       input logic signed [POS_W-1:0] b);
      logic [POS_W:0] sum;
      sum = {a[POS_W-1], a} + {b[POS_W-1], b};
      return $signed(sum[POS_W:1]);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d < DIM_MIN) r = DIM_MIN;
      else if (d > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   // The integer part of the coordinate sum only adds whole multiples of dim,
   // so the wrap by dim keeps just floor(frac * dim), which is already below dim.
   function automatic logic [COORD_IDX_W-1:0] texel_coord(input logic [SUM_W-1:0] dsum,
                                                          input logic [DIM_W-1:0] dim);
      logic [FRAC_SUM_W+DIM_W-1:0] prod;
      prod = (FRAC_SUM_W+DIM_W)'(dsum[FRAC_SUM_W-1:0]) * (FRAC_SUM_W+DIM_W)'(dim);
      return prod[FRAC_SUM_W+COORD_IDX_W-1:FRAC_SUM_W];
   endfunction

endpackage

// ===== rtl/core/tmts_front.sv =====
// Input side: takes commands, keeps the triangle corners and issues point and write jobs.
module tmts_front
   import tmts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_command,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [COORD_W-1:0]      req_tex_u,
   input  logic [COORD_W-1:0]      req_tex_v,
   input  logic [TEXEL_ADDR_W-1:0] req_texel_index,
   input  logic [RGB_W-1:0]        req_texel_rgb,
   output logic                    q_push,
   output job_type                 q_job,
   input  logic                    q_full
);

   typedef enum logic {FE_IDLE, FE_MID} fe_state_type;
   typedef enum logic [1:0] {MID_01, MID_12, MID_20} mid_sel_type;

   fe_state_type state_ff;
   mid_sel_type  sel_ff;
   logic [1:0]   count_ff;
   corner_type   corner_ff [2];
   corner_type   third_ff;

   corner_type in_corner;
   corner_type mid_a;
   corner_type mid_b;
   logic       accept;

   always_comb begin
      in_corner.pos.x = req_pos_x;
      in_corner.pos.y = req_pos_y;
      in_corner.pos.z = req_pos_z;
      in_corner.u     = req_tex_u;
      in_corner.v     = req_tex_v;
   end

   assign accept   = (state_ff == FE_IDLE) & req_push & ~q_full;
   assign req_full = (state_ff != FE_IDLE) | q_full;

   always_comb begin
      unique case (sel_ff)
         MID_01: begin
            mid_a = corner_ff[0];
            mid_b = corner_ff[1];
         end
         MID_12: begin
            mid_a = corner_ff[1];
            mid_b = third_ff;
         end
         MID_20: begin
            mid_a = third_ff;
            mid_b = corner_ff[0];
         end
         default: begin
            mid_a = corner_ff[0];
            mid_b = corner_ff[1];
         end
      endcase
   end

   always_comb begin
      q_job             = '0;
      q_job.texel_index = req_texel_index;
      q_job.rgb         = req_texel_rgb;
      unique case (state_ff)
         FE_IDLE: begin
            q_push            = accept;
            q_job.is_write    = (req_command == CMD_TEXEL_WRITE);
            q_job.pos         = in_corner.pos;
            q_job.du          = {req_tex_u, 1'b0};
            q_job.dv          = {req_tex_v, 1'b0};
            q_job.final_point = (count_ff != LAST_CORNER);
         end
         FE_MID: begin
            q_push            = ~q_full;
            q_job.is_write    = 1'b0;
            q_job.pos.x       = mid_pos(mid_a.pos.x, mid_b.pos.x);
            q_job.pos.y       = mid_pos(mid_a.pos.y, mid_b.pos.y);
            q_job.pos.z       = mid_pos(mid_a.pos.z, mid_b.pos.z);
            q_job.du          = SUM_W'(mid_a.u) + SUM_W'(mid_b.u);
            q_job.dv          = SUM_W'(mid_a.v) + SUM_W'(mid_b.v);
            q_job.final_point = (sel_ff == MID_20);
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         sel_ff   <= MID_01;
         count_ff <= 2'd0;
      end else begin
         unique case (state_ff)
            FE_IDLE: begin
               if (accept && req_command == CMD_VERTEX) begin
                  if (count_ff != LAST_CORNER) begin
                     corner_ff[count_ff[0]] <= in_corner;
                     count_ff               <= count_ff + 2'd1;
                  end else begin
                     // third corner: hold it and walk the edges 0-1, 1-2 and 2-0
                     third_ff <= in_corner;
                     count_ff <= 2'd0;
                     sel_ff   <= MID_01;
                     state_ff <= FE_MID;
                  end
               end
            end
            FE_MID: begin
               if (!q_full) begin
                  unique case (sel_ff)
                     MID_01:  sel_ff <= MID_12;
                     MID_12:  sel_ff <= MID_20;
                     MID_20:  state_ff <= FE_IDLE;
                     default: state_ff <= FE_IDLE;
                  endcase
               end
            end
            default: state_ff <= FE_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/tmts_job_queue.sv =====
// Short job queue between the front and the back.
module tmts_job_queue
   import tmts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type              mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff;
   logic [JOB_PTR_W-1:0] rd_ptr_ff;
   logic [JOB_CNT_W-1:0] cnt_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + JOB_PTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + JOB_PTR_W'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + JOB_CNT_W'(1);
         else if (!do_push && do_pop) cnt_ff <= cnt_ff - JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== rtl/core/tmts_back.sv =====
// Back end: texel addressing, texel store access and the result queue.
`include "triangle_midpoint_texel_sampler_top_defines.svh"
module tmts_back
   import tmts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    q_empty,
   input  job_type                 q_head,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic signed [POS_W-1:0] rsp_out_x,
   output logic signed [POS_W-1:0] rsp_out_y,
   output logic signed [POS_W-1:0] rsp_out_z,
   output logic [CHAN_W-1:0]       rsp_red,
   output logic [CHAN_W-1:0]       rsp_green,
   output logic [CHAN_W-1:0]       rsp_blue,
   output logic                    rsp_final_point
);

   // stage 1: column and row
   logic                    s1_vld_ff;
   job_type                 s1_job_ff;
   logic [COORD_IDX_W-1:0]  s1_x_ff;
   logic [COORD_IDX_W-1:0]  s1_y_ff;
   // stage 2: store address
   logic                    s2_vld_ff;
   job_type                 s2_job_ff;
   logic [TEXEL_ADDR_W-1:0] s2_addr_ff;
   logic [TEXEL_ADDR_W-1:0] s2_addr_in;
   logic [TEXEL_ADDR_W:0]   lin_addr;
   // stage 3: texel data
   logic                    s3_vld_ff;
   pos_type                 s3_pos_ff;
   logic                    s3_final_ff;
   logic [RGB_W-1:0]        rd_data_ff;

   logic [RGB_W-1:0]        texel_mem [TEXEL_DEPTH];

   point_type               out_mem_ff [OUT_DEPTH];
   point_type               out_head;
   point_type               push_point;
   logic [OUT_PTR_W-1:0]    out_wr_ptr_ff;
   logic [OUT_PTR_W-1:0]    out_rd_ptr_ff;
   logic [OUT_CNT_W-1:0]    out_cnt_ff;
   logic [OUT_CNT_W:0]      occupancy;
   logic                    out_pop;

   // reserve a result slot for every job still in the pipe
   assign occupancy = (OUT_CNT_W+1)'(out_cnt_ff) + (OUT_CNT_W+1)'(s1_vld_ff)
                    + (OUT_CNT_W+1)'(s2_vld_ff) + (OUT_CNT_W+1)'(s3_vld_ff);
   assign q_pop     = ~q_empty & (occupancy < (OUT_CNT_W+1)'(OUT_DEPTH));

   assign lin_addr   = (TEXEL_ADDR_W+1)'(s1_y_ff) * (TEXEL_ADDR_W+1)'(cfg.width)
                     + (TEXEL_ADDR_W+1)'(s1_x_ff);
   assign s2_addr_in = s1_job_ff.is_write ? s1_job_ff.texel_index
                                          : lin_addr[TEXEL_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= q_pop;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff & ~s2_job_ff.is_write;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff   <= q_head;
      s1_x_ff     <= texel_coord(q_head.du, cfg.width);
      s1_y_ff     <= texel_coord(q_head.dv, cfg.height);
      s2_job_ff   <= s1_job_ff;
      s2_addr_ff  <= s2_addr_in;
      s3_pos_ff   <= s2_job_ff.pos;
      s3_final_ff <= s2_job_ff.final_point;
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && s2_job_ff.is_write) texel_mem[s2_addr_ff] <= s2_job_ff.rgb;
      rd_data_ff <= texel_mem[s2_addr_ff];
   end

   always_comb begin
      push_point.pos         = s3_pos_ff;
      push_point.rgb         = cfg.present ? rd_data_ff : '0;
      push_point.final_point = s3_final_ff;
   end

   assign rsp_empty       = (out_cnt_ff == '0);
   assign out_pop         = rsp_pop & ~rsp_empty;
   assign out_head        = out_mem_ff[out_rd_ptr_ff];
   assign rsp_out_x       = out_head.pos.x;
   assign rsp_out_y       = out_head.pos.y;
   assign rsp_out_z       = out_head.pos.z;
   assign rsp_red         = out_head.rgb[RGB_W-1:2*CHAN_W];
   assign rsp_green       = out_head.rgb[2*CHAN_W-1:CHAN_W];
   assign rsp_blue        = out_head.rgb[CHAN_W-1:0];
   assign rsp_final_point = out_head.final_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_cnt_ff    <= '0;
      end else begin
         if (s3_vld_ff) out_wr_ptr_ff <= out_wr_ptr_ff + OUT_PTR_W'(1);
         if (out_pop) out_rd_ptr_ff <= out_rd_ptr_ff + OUT_PTR_W'(1);
         if (s3_vld_ff && !out_pop) out_cnt_ff <= out_cnt_ff + OUT_CNT_W'(1);
         else if (!s3_vld_ff && out_pop) out_cnt_ff <= out_cnt_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_vld_ff) out_mem_ff[out_wr_ptr_ff] <= push_point;
   end

   `TMTS_ASSERT_SAME(a_result_room, 1'b1, occupancy <= (OUT_CNT_W+1)'(OUT_DEPTH), "queue overrun")
   `TMTS_ASSERT_NEXT(a_read_flows, s2_vld_ff && !s2_job_ff.is_write, s3_vld_ff, "point lost")
   `TMTS_ASSERT_NEXT(a_write_silent, s2_vld_ff && s2_job_ff.is_write, !s3_vld_ff, "write emitted")

endmodule

// ===== rtl/core/triangle_midpoint_texel_sampler_top.sv =====
// An accepted vertex passes the job queue, the back end stages and the result queue.
// Texel writes and first or second vertices enter back to back while the queue has room;
// a third vertex holds the input while the front issues the vertex and its three midpoints.
// The back end retires one job per cycle through the single texel store port while the
// result queue has room. Reset is synchronous: queues and control clear, width/height go
// to 1, texture off; the texel store is not cleared.
module triangle_midpoint_texel_sampler_top
   import tmts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_command,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [COORD_W-1:0]      req_tex_u,
   input  logic [COORD_W-1:0]      req_tex_v,
   input  logic [TEXEL_ADDR_W-1:0] req_texel_index,
   input  logic [RGB_W-1:0]        req_texel_rgb,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic signed [POS_W-1:0] rsp_out_x,
   output logic signed [POS_W-1:0] rsp_out_y,
   output logic signed [POS_W-1:0] rsp_out_z,
   output logic [CHAN_W-1:0]       rsp_red,
   output logic [CHAN_W-1:0]       rsp_green,
   output logic [CHAN_W-1:0]       rsp_blue,
   output logic                    rsp_final_point,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [DIM_W-1:0]        csr_wdata
);

   logic [DIM_W-1:0] tex_width_ff;
   logic [DIM_W-1:0] tex_height_ff;
   logic             tex_present_ff;
   cfg_type          cfg;

   logic             q_push;
   job_type          q_job;
   logic             q_full;
   logic             q_pop;
   job_type          q_head;
   logic             q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff   <= DIM_MIN;
         tex_height_ff  <= DIM_MIN;
         tex_present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:   tex_width_ff   <= csr_wdata;
            CSR_TEX_HEIGHT:  tex_height_ff  <= csr_wdata;
            CSR_TEX_PRESENT: tex_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width   = clamp_dim(tex_width_ff);
      cfg.height  = clamp_dim(tex_height_ff);
      cfg.present = tex_present_ff;
   end

   tmts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_tex_u       (req_tex_u),
      .req_tex_v       (req_tex_v),
      .req_texel_index (req_texel_index),
      .req_texel_rgb   (req_texel_rgb),
      .q_push          (q_push),
      .q_job           (q_job),
      .q_full          (q_full)
   );

   tmts_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   tmts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_final_point (rsp_final_point)
   );

endmodule

// ===== sim/tb_triangle_midpoint_texel_sampler_top.sv =====
// Self-checking testbench for the triangle midpoint texel sampler top level.
`timescale 1ns / 100ps

module tb_triangle_midpoint_texel_sampler_top;
   import tmts_pkg::*;

   // Register index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX = '1;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic                    command;
      pos_type                 pos;
      logic [COORD_W-1:0]      u;
      logic [COORD_W-1:0]      v;
      logic [TEXEL_ADDR_W-1:0] index;
      logic [RGB_W-1:0]        rgb;
   } req_item_type;

   typedef struct {
      pos_type             pos;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic                last;
   } exp_point_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic                    req_command;
   logic signed [POS_W-1:0] req_pos_x;
   logic signed [POS_W-1:0] req_pos_y;
   logic signed [POS_W-1:0] req_pos_z;
   logic [COORD_W-1:0]      req_tex_u;
   logic [COORD_W-1:0]      req_tex_v;
   logic [TEXEL_ADDR_W-1:0] req_texel_index;
   logic [RGB_W-1:0]        req_texel_rgb;
   logic                    rsp_pop = 1'b0;
   logic                    rsp_empty;
   logic signed [POS_W-1:0] rsp_out_x;
   logic signed [POS_W-1:0] rsp_out_y;
   logic signed [POS_W-1:0] rsp_out_z;
   logic [CHAN_W-1:0]       rsp_red;
   logic [CHAN_W-1:0]       rsp_green;
   logic [CHAN_W-1:0]       rsp_blue;
   logic                    rsp_final_point;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [DIM_W-1:0]        csr_wdata;

   // Shadow of the block: configuration, held corners, texel contents.
   logic [DIM_W-1:0]        cfg_width;
   logic [DIM_W-1:0]        cfg_height;
   logic                    cfg_present;
   corner_type              corners [2];
   int                      corners_held;
   logic [RGB_W-1:0]        texel_shadow [int];
   exp_point_type           pending_points [$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int fail_count = 0;
   int sent_count = 0;

   triangle_midpoint_texel_sampler_top dut (.*);

   always #1 clock = ~clock;

   function automatic longint unsigned clamp_size(logic [DIM_W-1:0] r);
      if (r == 0) return 1;
      if (r > 256) return 256;
      return r;
   endfunction

   // du and dv carry one extra fraction bit: they are sums of two coordinates.
   function automatic int texel_address(logic [SUM_W-1:0] du, logic [SUM_W-1:0] dv);
      longint unsigned w, h, col, row;
      w = clamp_size(cfg_width);
      h = clamp_size(cfg_height);
      col = ((64'(du) * w) >> (COORD_FRAC_BITS + 1)) % w;
      row = ((64'(dv) * h) >> (COORD_FRAC_BITS + 1)) % h;
      return int'((row * w + col) % TEXEL_DEPTH);
   endfunction

   function automatic pos_type halfway(pos_type a, pos_type b);
      pos_type m;
      longint s;
      s = longint'(a.x) + longint'(b.x);
      m.x = POS_W'(s >>> 1);
      s = longint'(a.y) + longint'(b.y);
      m.y = POS_W'(s >>> 1);
      s = longint'(a.z) + longint'(b.z);
      m.z = POS_W'(s >>> 1);
      return m;
   endfunction

   function automatic pos_type make_pos(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                        logic signed [POS_W-1:0] z);
      pos_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   task automatic queue_point(pos_type p, logic [SUM_W-1:0] du, logic [SUM_W-1:0] dv,
                              logic last);
      exp_point_type pt;
      logic [RGB_W-1:0] rgb;
      int a;
      rgb = '0;
      if (cfg_present) begin
         a = texel_address(du, dv);
         if (texel_shadow.exists(a)) rgb = texel_shadow[a];
      end
      pt.pos = p;
      pt.red = rgb[23:16];
      pt.green = rgb[15:8];
      pt.blue = rgb[7:0];
      pt.last = last;
      pending_points.push_back(pt);
   endtask

   task automatic queue_midpoint(corner_type a, corner_type b, logic last);
      queue_point(halfway(a.pos, b.pos), SUM_W'(a.u) + SUM_W'(b.u),
                  SUM_W'(a.v) + SUM_W'(b.v), last);
   endtask

   task automatic predict_points(req_item_type it);
      corner_type cur;
      if (it.command == CMD_TEXEL_WRITE) begin
         texel_shadow[int'(it.index)] = it.rgb;
         return;
      end
      cur.pos = it.pos;
      cur.u = it.u;
      cur.v = it.v;
      if (corners_held < 2) begin
         corners[corners_held] = cur;
         corners_held++;
         queue_point(cur.pos, {cur.u, 1'b0}, {cur.v, 1'b0}, 1'b1);
      end else begin
         queue_point(cur.pos, {cur.u, 1'b0}, {cur.v, 1'b0}, 1'b0);
         queue_midpoint(corners[0], corners[1], 1'b0);
         queue_midpoint(corners[1], cur, 1'b0);
         queue_midpoint(cur, corners[0], 1'b1);
         corners_held = 0;
      end
   endtask

   // Enter and leave just after a rising edge; push stays high into the next item.
   task automatic push_item(req_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_command <= it.command;
      req_pos_x <= it.pos.x;
      req_pos_y <= it.pos.y;
      req_pos_z <= it.pos.z;
      req_tex_u <= it.u;
      req_tex_v <= it.v;
      req_texel_index <= it.index;
      req_texel_rgb <= it.rgb;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      sent_count++;
      predict_points(it);
   endtask

   task automatic write_texel(logic [TEXEL_ADDR_W-1:0] index, logic [RGB_W-1:0] rgb);
      req_item_type it;
      it.command = CMD_TEXEL_WRITE;
      it.pos = make_pos($urandom, $urandom, $urandom);
      it.u = COORD_W'($urandom);
      it.v = COORD_W'($urandom);
      it.index = index;
      it.rgb = rgb;
      push_item(it);
   endtask

   // Load every texel this vertex will sample before sending it.
   task automatic submit_vertex(pos_type p, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      logic [SUM_W-1:0] du [4];
      logic [SUM_W-1:0] dv [4];
      int n, a;
      req_item_type it;
      if (cfg_present) begin
         du[0] = {u, 1'b0};
         dv[0] = {v, 1'b0};
         n = 1;
         if (corners_held == 2) begin
            du[1] = SUM_W'(corners[0].u) + SUM_W'(corners[1].u);
            dv[1] = SUM_W'(corners[0].v) + SUM_W'(corners[1].v);
            du[2] = SUM_W'(corners[1].u) + SUM_W'(u);
            dv[2] = SUM_W'(corners[1].v) + SUM_W'(v);
            du[3] = SUM_W'(u) + SUM_W'(corners[0].u);
            dv[3] = SUM_W'(v) + SUM_W'(corners[0].v);
            n = 4;
         end
         for (int k = 0; k < n; k++) begin
            a = texel_address(du[k], dv[k]);
            if (!texel_shadow.exists(a)) write_texel(TEXEL_ADDR_W'(a), RGB_W'($urandom));
         end
      end
      it.command = CMD_VERTEX;
      it.pos = p;
      it.u = u;
      it.v = v;
      it.index = TEXEL_ADDR_W'($urandom);
      it.rgb = RGB_W'($urandom);
      push_item(it);
   endtask

   // Hold input until every point has come back, then let trailing writes settle.
   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic present,
                            bit poke_spare);
      csr_we <= 1'b1;
      csr_index <= CSR_TEX_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      cfg_width = w;
      csr_index <= CSR_TEX_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      cfg_height = h;
      csr_index <= CSR_TEX_PRESENT;
      csr_wdata <= {8'($urandom), present};
      @(posedge clock);
      cfg_present = present;
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= '1;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic check_point();
      exp_point_type exp_pt;
      if (pending_points.size() == 0) begin
         $error("unexpected point: x %0d y %0d z %0d", rsp_out_x, rsp_out_y, rsp_out_z);
         fail_count++;
         return;
      end
      exp_pt = pending_points.pop_front();
      if (rsp_out_x !== exp_pt.pos.x) begin
         $error("out_x: expected %0d, got %0d", exp_pt.pos.x, rsp_out_x);
         fail_count++;
      end
      if (rsp_out_y !== exp_pt.pos.y) begin
         $error("out_y: expected %0d, got %0d", exp_pt.pos.y, rsp_out_y);
         fail_count++;
      end
      if (rsp_out_z !== exp_pt.pos.z) begin
         $error("out_z: expected %0d, got %0d", exp_pt.pos.z, rsp_out_z);
         fail_count++;
      end
      if (rsp_red !== exp_pt.red) begin
         $error("red: expected %0d, got %0d", exp_pt.red, rsp_red);
         fail_count++;
      end
      if (rsp_green !== exp_pt.green) begin
         $error("green: expected %0d, got %0d", exp_pt.green, rsp_green);
         fail_count++;
      end
      if (rsp_blue !== exp_pt.blue) begin
         $error("blue: expected %0d, got %0d", exp_pt.blue, rsp_blue);
         fail_count++;
      end
      if (rsp_final_point !== exp_pt.last) begin
         $error("final_point: expected %0d, got %0d", exp_pt.last, rsp_final_point);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_point();
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   function automatic logic [DIM_W-1:0] pick_size();
      case ($urandom_range(11))
         0: return DIM_W'(0);
         1: return DIM_W'(1);
         2: return DIM_W'(2);
         3: return DIM_W'(3);
         4: return DIM_W'(16);
         5: return DIM_W'(255);
         6: return DIM_W'(256);
         7: return DIM_W'(300);
         8: return DIM_W'(511);
         default: return DIM_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] random_coord_pos();
      case ($urandom_range(9))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return -32'sd1;
         default: return POS_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] random_tex();
      if ($urandom_range(4) < 3) return COORD_W'($urandom);
      return COORD_W'($urandom_range(32'h1_FFFF));
   endfunction

   // Positions at the signed limits, where midpoint sums overflow 32 bits.
   task automatic test_vertex_extremes();
      write_texel('1, '1);
      write_texel('0, '0);
      submit_vertex(make_pos(POS_MAX, POS_MAX, POS_MIN), COORD_MAX, '0);
      submit_vertex(make_pos(POS_MAX, POS_MIN, POS_MAX), '0, COORD_MAX);
      submit_vertex(make_pos(POS_MIN, -32'sd1, POS_MAX), COORD_MAX, COORD_MAX);
      submit_vertex(make_pos(-32'sd1, 32'sd1, 32'sd0), '0, '0);
      submit_vertex(make_pos(32'sd0, -32'sd1, POS_MIN), 20'h0_8000, 20'h1_0000);
      submit_vertex(make_pos(32'sd1, 32'sd0, POS_MIN), 20'h0_0001, 20'hF_FFFF);
   endtask

   // Full-size texture sampled at coordinate extremes, then a 1x1 texture.
   task automatic test_texture_extremes();
      wait_for_drain();
      configure(DIM_W'(256), DIM_W'(256), 1'b1, 1'b0);
      submit_vertex(make_pos(32'sd5, 32'sd6, 32'sd7), '0, '0);
      submit_vertex(make_pos(-32'sd5, 32'sd9, 32'sd1), COORD_MAX, COORD_MAX);
      submit_vertex(make_pos(32'sd3, -32'sd4, 32'sd2), 20'h0_8000, 20'h1_FFFF);
      wait_for_drain();
      configure(DIM_W'(1), DIM_W'(1), 1'b1, 1'b0);
      submit_vertex(make_pos(POS_MAX, 32'sd0, POS_MIN), COORD_MAX, 20'h0_4000);
      submit_vertex(make_pos(POS_MIN, 32'sd0, POS_MAX), 20'h0_C000, '0);
      submit_vertex(make_pos(32'sd2, 32'sd4, 32'sd8), 20'h1_0000, COORD_MAX);
   endtask

   // Width and height outside 1..256 saturate; the spare index is ignored.
   task automatic test_dim_saturation();
      wait_for_drain();
      configure(DIM_W'(0), DIM_W'(511), 1'b1, 1'b1);
      submit_vertex(make_pos(32'sd10, 32'sd20, 32'sd30), 20'h0_FFFF, 20'h0_7FFF);
      submit_vertex(make_pos(32'sd40, 32'sd50, 32'sd60), 20'h3_0001, 20'hF_0000);
      submit_vertex(make_pos(32'sd70, 32'sd80, 32'sd90), '0, 20'h0_0001);
      wait_for_drain();
      configure(DIM_W'(300), DIM_W'(0), 1'b1, 1'b0);
      submit_vertex(make_pos(-32'sd10, -32'sd20, -32'sd30), 20'h0_FFFF, COORD_MAX);
      submit_vertex(make_pos(-32'sd40, -32'sd50, -32'sd60), 20'h8_8000, 20'h0_0000);
      submit_vertex(make_pos(-32'sd70, -32'sd80, -32'sd90), 20'h0_0001, 20'h2_0000);
   endtask

   // Texel loads for sampled addresses count toward the item budget of a phase.
   task automatic run_traffic_phase(int idle_pct, int stall_pct, int n_items);
      logic [DIM_W-1:0] w, h;
      longint unsigned area;
      logic [TEXEL_ADDR_W-1:0] index;
      int stop_count;
      for (int half = 0; half < 2; half++) begin
         wait_for_drain();
         send_idle_pct = idle_pct;
         pop_stall_pct = stall_pct;
         w = pick_size();
         h = pick_size();
         configure(w, h, $urandom_range(3) != 0, 1'b0);
         area = clamp_size(w) * clamp_size(h);
         stop_count = sent_count + n_items / 2;
         while (sent_count < stop_count) begin
            if ($urandom_range(4) == 0) begin
               // overwrite texels inside the sampled region half the time
               if ($urandom_range(1) == 0) index = TEXEL_ADDR_W'($urandom);
               else index = TEXEL_ADDR_W'($urandom_range(int'(area - 1)));
               write_texel(index, RGB_W'($urandom));
            end else begin
               submit_vertex(make_pos(random_coord_pos(), random_coord_pos(),
                                      random_coord_pos()), random_tex(), random_tex());
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(0, 0, 80);
      run_traffic_phase(46, 0, 80);
      run_traffic_phase(0, 46, 80);
      run_traffic_phase(25, 25, 80);
   endtask

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_command <= CMD_VERTEX;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      req_tex_u <= '0;
      req_tex_v <= '0;
      req_texel_index <= '0;
      req_texel_rgb <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_TEX_WIDTH;
      csr_wdata <= '0;
      cfg_width = DIM_W'(1);
      cfg_height = DIM_W'(1);
      cfg_present = 1'b0;
      corners_held = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_vertex_extremes();
      test_texture_extremes();
      test_dim_saturation();
      test_random_traffic();
      wait_for_drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
